// ===== src/tedq_pkg.sv =====
// ----------------------------------------------------------------------------
// tedq_pkg
// Types and constants shared by the timestamped event delay queue modules.
// ----------------------------------------------------------------------------
package tedq_pkg;

	localparam int DUE_W   = 64;
	localparam int PAY_W   = 64;
	localparam int OFF_W   = 32;
	localparam int LAT_W   = 32;
	localparam int CAP_W   = 5;
	localparam int ROOM_W  = 7;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LATENCY  = 1'b0,
		REG_CAPACITY = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_END  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_EVENT = 2'd0,
		KIND_ACK   = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_OFFSET   = 3'd1,
		ERR_FULL     = 3'd2,
		ERR_OVERFLOW = 3'd3,
		ERR_DEST     = 3'd4,
		ERR_LATE     = 3'd5,
		ERR_NO_SINK  = 3'd6
	} err_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [DUE_W-1:0] a;
		logic [DUE_W-1:0] b;
	} alu_req_t;

	// For an add, flag is the carry out; for a subtract, flag is set when a < b.
	typedef struct packed {
		logic [DUE_W-1:0] res;
		logic             flag;
	} alu_rsp_t;

	typedef struct packed {
		kind_t            kind;
		logic             strm;
		logic [OFF_W-1:0] off;
		logic [PAY_W-1:0] pay;
		err_t             err;
		logic             last;
	} result_t;

endpackage

// ===== src/timestamped_event_delay_queue.sv =====
// ----------------------------------------------------------------------------
// timestamped_event_delay_queue
// Two ring queues that delay timestamped events by a programmable latency.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; in_ready is high only while idle.
// A push checks capacity and offset, adds latency and block position, stores
// the entry and hands over its single result. An end-of-block transaction
// computes the block end, scans the due heads of each queue, checks room and
// lateness, then emits each released event and one more result for the
// block-done marker. All arithmetic goes through one shared 64-bit
// adder/subtractor, and each queue's storage has a single registered read
// port, so queued entries are visited one at a time. Writing a configuration
// register empties both queues and resets the block position to zero.
module timestamped_event_delay_queue
	import tedq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic                 stream,
	input  logic [OFF_W-1:0]     offset_in_block,
	input  logic [PAY_W-1:0]     payload,
	input  logic [31:0]          block_frames,
	input  logic [ROOM_W-1:0]    room_stream_one,
	input  logic [ROOM_W-1:0]    room_stream_two,
	input  logic                 sink_two_present,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           kind,
	output logic                 out_stream,
	output logic [OFF_W-1:0]     out_offset,
	output logic [PAY_W-1:0]     out_payload,
	output logic [2:0]           error_code,
	output logic                 last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = AW + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_CHK,
		S_PUSH_ADD,
		S_PUSH_DUE,
		S_END_ADD,
		S_SCAN_RD,
		S_SCAN_END,
		S_SCAN_LATE,
		S_CHECK,
		S_REL_RD,
		S_REL_OUT,
		S_EMIT
	} state_t;

	state_t state_q, ret_q;

	logic [AW-1:0]    head_one_q, tail_one_q, head_two_q, tail_two_q;
	logic [CW-1:0]    count_one_q, count_two_q, n_one_q, n_two_q, pos_q;
	logic [DUE_W-1:0] frontier_q;
	logic [LAT_W-1:0] latency_q;
	logic [CAP_W-1:0] cap_q;
	logic             qsel_q, late_q;
	result_t          out_q;
	logic             out_valid_q;

	logic              cmd_q, stream_q, sink_two_q;
	logic [OFF_W-1:0]  off_q;
	logic [PAY_W-1:0]  pay_q;
	logic [31:0]       frames_q;
	logic [ROOM_W-1:0] room_one_q, room_two_q;
	logic [DUE_W-1:0]  acc_q, end_q;

	logic [AW-1:0]    head_sel, push_tail, rd_addr;
	logic [CW-1:0]    count_sel, n_sel, push_cnt;
	logic [SW-1:0]    addr_sum;
	logic [CAP_W-1:0] cap_use;
	logic             full, scan_stop;
	logic [DUE_W-1:0] due_one_rd, due_two_rd, due_rd;
	logic [PAY_W-1:0] pay_one_rd, pay_two_rd, pay_rd;
	logic             wr_one, wr_two;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;

	function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] i);
		logic [SW-1:0] nxt;
		nxt = SW'(i) + SW'(1);
		return (nxt >= SW'(QUEUE_DEPTH)) ? '0 : AW'(nxt);
	endfunction

	function automatic result_t mk_result(input kind_t k, input logic s,
		input logic [OFF_W-1:0] o, input logic [PAY_W-1:0] p, input err_t e,
		input logic l);
		result_t r;
		r.kind = k;
		r.strm = s;
		r.off  = o;
		r.pay  = p;
		r.err  = e;
		r.last = l;
		return r;
	endfunction

	function automatic result_t mk_error(input err_t e);
		return mk_result(KIND_ERROR, 1'b0, '0, '0, e, 1'b1);
	endfunction

	// Read address: selected head plus scan position, modulo the queue depth.
	assign head_sel  = qsel_q ? head_two_q : head_one_q;
	assign count_sel = qsel_q ? count_two_q : count_one_q;
	assign n_sel     = qsel_q ? n_two_q : n_one_q;
	assign addr_sum  = SW'(head_sel) + SW'(pos_q);
	assign rd_addr   = (addr_sum >= SW'(QUEUE_DEPTH)) ?
		AW'(addr_sum - SW'(QUEUE_DEPTH)) : AW'(addr_sum);

	assign due_rd = qsel_q ? due_two_rd : due_one_rd;
	assign pay_rd = qsel_q ? pay_two_rd : pay_one_rd;

	assign push_cnt  = stream_q ? count_two_q : count_one_q;
	assign push_tail = stream_q ? tail_two_q : tail_one_q;

	always_comb begin
		if (cap_q == '0) begin
			cap_use = CAP_W'(1);
		end else if (cap_q > CAP_W'(QUEUE_DEPTH)) begin
			cap_use = CAP_W'(QUEUE_DEPTH);
		end else begin
			cap_use = cap_q;
		end
	end

	assign full = (CAP_W'(push_cnt) >= cap_use);

	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = frontier_q;
		alu_req.b  = due_rd;
		case (state_q)
			S_PUSH_CHK: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = DUE_W'(off_q);
				alu_req.b  = DUE_W'(frames_q);
			end
			S_PUSH_ADD: begin
				alu_req.a = DUE_W'(off_q);
				alu_req.b = DUE_W'(latency_q);
			end
			S_PUSH_DUE: begin
				alu_req.b = acc_q;
			end
			S_END_ADD: begin
				alu_req.b = DUE_W'(frames_q);
			end
			S_SCAN_END: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = due_rd;
				alu_req.b  = end_q;
			end
			S_SCAN_LATE, S_REL_OUT: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = due_rd;
				alu_req.b  = frontier_q;
			end
			default: begin
				alu_req.op = ALU_ADD;
			end
		endcase
	end

	tedq_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	// A queue scan stops at the end of the queue or at the first head not yet due.
	assign scan_stop = ((state_q == S_SCAN_RD) && (pos_q == count_sel)) ||
		((state_q == S_SCAN_END) && !alu_rsp.flag);

	assign wr_one = (state_q == S_PUSH_DUE) && !alu_rsp.flag && !stream_q;
	assign wr_two = (state_q == S_PUSH_DUE) && !alu_rsp.flag && stream_q;

	tedq_ram #(.WIDTH(DUE_W), .DEPTH(QUEUE_DEPTH)) u_due_one (
		.clk(clk), .we(wr_one), .waddr(push_tail), .wdata(alu_rsp.res),
		.raddr(rd_addr), .rdata(due_one_rd)
	);

	tedq_ram #(.WIDTH(PAY_W), .DEPTH(QUEUE_DEPTH)) u_pay_one (
		.clk(clk), .we(wr_one), .waddr(push_tail), .wdata(pay_q),
		.raddr(rd_addr), .rdata(pay_one_rd)
	);

	tedq_ram #(.WIDTH(DUE_W), .DEPTH(QUEUE_DEPTH)) u_due_two (
		.clk(clk), .we(wr_two), .waddr(push_tail), .wdata(alu_rsp.res),
		.raddr(rd_addr), .rdata(due_two_rd)
	);

	tedq_ram #(.WIDTH(PAY_W), .DEPTH(QUEUE_DEPTH)) u_pay_two (
		.clk(clk), .we(wr_two), .waddr(push_tail), .wdata(pay_q),
		.raddr(rd_addr), .rdata(pay_two_rd)
	);

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			cmd_q      <= cmd;
			stream_q   <= stream;
			off_q      <= offset_in_block;
			pay_q      <= payload;
			frames_q   <= block_frames;
			room_one_q <= room_stream_one;
			room_two_q <= room_stream_two;
			sink_two_q <= sink_two_present;
		end
		if (state_q == S_PUSH_ADD) begin
			acc_q <= alu_rsp.res;
		end
		if (state_q == S_END_ADD) begin
			end_q <= alu_rsp.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			head_one_q  <= '0;
			tail_one_q  <= '0;
			count_one_q <= '0;
			head_two_q  <= '0;
			tail_two_q  <= '0;
			count_two_q <= '0;
			n_one_q     <= '0;
			n_two_q     <= '0;
			pos_q       <= '0;
			frontier_q  <= '0;
			latency_q   <= '0;
			cap_q       <= CAP_RESET;
			qsel_q      <= 1'b0;
			late_q      <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (cmd == CMD_END) ? S_END_ADD : S_PUSH_CHK;
					end
				end
				S_PUSH_CHK: begin
					if (full) begin
						out_q       <= mk_error(ERR_FULL);
						out_valid_q <= 1'b1;
						ret_q       <= S_IDLE;
						state_q     <= S_EMIT;
					end else if (off_q[OFF_W-1] || !alu_rsp.flag) begin
						out_q       <= mk_error(ERR_OFFSET);
						out_valid_q <= 1'b1;
						ret_q       <= S_IDLE;
						state_q     <= S_EMIT;
					end else begin
						state_q <= S_PUSH_ADD;
					end
				end
				S_PUSH_ADD: begin
					state_q <= S_PUSH_DUE;
				end
				S_PUSH_DUE: begin
					if (alu_rsp.flag) begin
						out_q <= mk_error(ERR_OVERFLOW);
					end else begin
						if (stream_q) begin
							tail_two_q  <= wrap_next(tail_two_q);
							count_two_q <= count_two_q + CW'(1);
						end else begin
							tail_one_q  <= wrap_next(tail_one_q);
							count_one_q <= count_one_q + CW'(1);
						end
						out_q <= mk_result(KIND_ACK, 1'b0, '0, '0, ERR_NONE, 1'b1);
					end
					out_valid_q <= 1'b1;
					ret_q       <= S_IDLE;
					state_q     <= S_EMIT;
				end
				S_END_ADD: begin
					if (alu_rsp.flag) begin
						out_q       <= mk_error(ERR_OVERFLOW);
						out_valid_q <= 1'b1;
						ret_q       <= S_IDLE;
						state_q     <= S_EMIT;
					end else begin
						qsel_q  <= 1'b0;
						pos_q   <= '0;
						late_q  <= 1'b0;
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					if (!scan_stop) begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: begin
					if (!scan_stop) begin
						state_q <= S_SCAN_LATE;
					end
				end
				S_SCAN_LATE: begin
					if (alu_rsp.flag) begin
						late_q <= 1'b1;
					end
					pos_q   <= pos_q + CW'(1);
					state_q <= S_SCAN_RD;
				end
				S_CHECK: begin
					qsel_q <= 1'b0;
					pos_q  <= '0;
					if (ROOM_W'(n_one_q) > room_one_q) begin
						out_q       <= mk_error(ERR_DEST);
						out_valid_q <= 1'b1;
						ret_q       <= S_IDLE;
						state_q     <= S_EMIT;
					end else if (!sink_two_q && (count_two_q != '0)) begin
						out_q       <= mk_error(ERR_NO_SINK);
						out_valid_q <= 1'b1;
						ret_q       <= S_IDLE;
						state_q     <= S_EMIT;
					end else if (sink_two_q && (ROOM_W'(n_two_q) > room_two_q)) begin
						out_q       <= mk_error(ERR_DEST);
						out_valid_q <= 1'b1;
						ret_q       <= S_IDLE;
						state_q     <= S_EMIT;
					end else if (late_q) begin
						out_q       <= mk_error(ERR_LATE);
						out_valid_q <= 1'b1;
						ret_q       <= S_IDLE;
						state_q     <= S_EMIT;
					end else begin
						state_q <= S_REL_RD;
					end
				end
				S_REL_RD: begin
					if (n_sel != '0) begin
						state_q <= S_REL_OUT;
					end else if (!qsel_q) begin
						qsel_q <= 1'b1;
					end else begin
						frontier_q  <= end_q;
						out_q       <= mk_result(KIND_DONE, 1'b0, '0, '0, ERR_NONE, 1'b1);
						out_valid_q <= 1'b1;
						ret_q       <= S_IDLE;
						state_q     <= S_EMIT;
					end
				end
				S_REL_OUT: begin
					out_q <= mk_result(KIND_EVENT, qsel_q, alu_rsp.res[OFF_W-1:0], pay_rd,
						ERR_NONE, 1'b0);
					if (qsel_q) begin
						head_two_q  <= wrap_next(head_two_q);
						count_two_q <= count_two_q - CW'(1);
						n_two_q     <= n_two_q - CW'(1);
					end else begin
						head_one_q  <= wrap_next(head_one_q);
						count_one_q <= count_one_q - CW'(1);
						n_one_q     <= n_one_q - CW'(1);
					end
					out_valid_q <= 1'b1;
					ret_q       <= S_REL_RD;
					state_q     <= S_EMIT;
				end
				S_EMIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// The stop position of a scan is the number of due heads in that queue.
			if (scan_stop) begin
				if (!qsel_q) begin
					n_one_q <= pos_q;
					qsel_q  <= 1'b1;
					pos_q   <= '0;
					state_q <= S_SCAN_RD;
				end else begin
					n_two_q <= pos_q;
					state_q <= S_CHECK;
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_LATENCY: begin
						latency_q <= cfg_data[LAT_W-1:0];
					end
					REG_CAPACITY: begin
						cap_q <= cfg_data[CAP_W-1:0];
					end
					default: begin
						latency_q <= latency_q;
					end
				endcase
				head_one_q  <= '0;
				tail_one_q  <= '0;
				count_one_q <= '0;
				head_two_q  <= '0;
				tail_two_q  <= '0;
				count_two_q <= '0;
				frontier_q  <= '0;
			end
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign out_stream  = out_q.strm;
	assign out_offset  = out_q.off;
	assign out_payload = out_q.pay;
	assign error_code  = out_q.err;
	assign last        = out_q.last;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("result pending while accepting a new transaction");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("block stayed ready after accepting a transaction");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_one_q <= CW'(QUEUE_DEPTH)) && (count_two_q <= CW'(QUEUE_DEPTH)))
		else $error("queue count exceeds depth");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_ERROR)) |-> (last && (error_code != ERR_NONE)))
		else $error("error result not marked as final");

	a_event_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_EVENT)) |-> (!last && (cmd_q == CMD_END)))
		else $error("released event outside an end-of-block transaction");

endmodule

// ===== src/tedq_ram.sv =====
// ----------------------------------------------------------------------------
// tedq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tedq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/tedq_alu.sv =====
// ----------------------------------------------------------------------------
// tedq_alu
// Shared 64-bit add/subtract unit with carry and borrow flag.
// ----------------------------------------------------------------------------
module tedq_alu
	import tedq_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic             is_sub;
	logic [DUE_W:0]   sum;
	logic [DUE_W-1:0] b_op;

	assign is_sub = (req.op == ALU_SUB);
	assign b_op   = is_sub ? ~req.b : req.b;
	assign sum    = {1'b0, req.a} + {1'b0, b_op} + (DUE_W + 1)'(is_sub);

	assign rsp.res  = sum[DUE_W-1:0];
	assign rsp.flag = is_sub ? ~sum[DUE_W] : sum[DUE_W];

endmodule
